>>> rtl/ghs_pkg.sv
// Shared types and constants for the gzip member header stripper.
// No dependencies; used by every module under rtl.
package ghs_pkg;

  typedef enum logic [3:0] {
    PH_MAGIC0  = 4'd0,
    PH_MAGIC1  = 4'd1,
    PH_METHOD  = 4'd2,
    PH_FLAGS   = 4'd3,
    PH_FIXED   = 4'd4,
    PH_XLEN0   = 4'd5,
    PH_XLEN1   = 4'd6,
    PH_EXTRA   = 4'd7,
    PH_NAME    = 4'd8,
    PH_COMMENT = 4'd9,
    PH_HCRC0   = 4'd10,
    PH_HCRC1   = 4'd11,
    PH_PAYLOAD = 4'd12,
    PH_ERROR   = 4'd13
  } phase_e;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_MAGIC  = 2'd1;
  localparam logic [1:0] ERR_METHOD = 2'd2;
  localparam logic [1:0] ERR_TRUNC  = 2'd3;

  localparam logic [7:0] MAGIC0_BYTE = 8'h1F;
  localparam logic [7:0] MAGIC1_BYTE = 8'h8B;
  localparam logic [7:0] DEFLATE_CM  = 8'h08;

  // Only FLG bits 1 to 4 matter; they are kept in a 4-bit register.
  localparam int FlagLsb     = 1;
  localparam int FlagMsb     = 4;
  localparam int FlagHcrc    = 0;
  localparam int FlagExtra   = 1;
  localparam int FlagName    = 2;
  localparam int FlagComment = 3;

  localparam logic [2:0] FIXED_LAST = 3'd5;

  // One input byte with its classification, as held in the front queue.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_magic0;
    logic       is_magic1;
    logic       is_deflate;
    logic       is_zero;
  } item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_payload;
    logic       header_done;
    logic [1:0] error_code;
    logic       last;
  } result_t;

endpackage

>>> rtl/ghs_front.sv
// Front end: accepts raw bytes, classifies them and holds them in a
// two-entry queue for the parser. Depends on ghs_pkg.
module ghs_front import ghs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       item_valid_o,
  output item_t      item_o,
  input  logic       item_take_i
);

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       wr_en;
  logic       rd_en;
  item_t      item_in;

  assign full         = (count_q == 2'd2);
  assign wr_en        = push && !full;
  assign item_valid_o = (count_q != 2'd0);
  assign rd_en        = item_take_i && item_valid_o;
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    item_in.data       = in_byte_i;
    item_in.last       = in_last_i;
    item_in.is_magic0  = (in_byte_i == MAGIC0_BYTE);
    item_in.is_magic1  = (in_byte_i == MAGIC1_BYTE);
    item_in.is_deflate = (in_byte_i == DEFLATE_CM);
    item_in.is_zero    = (in_byte_i == 8'd0);
  end

  always_comb begin
    wr_ptr_d = wr_en ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

>>> rtl/ghs_parser.sv
// Back end: header state machine. Takes one classified byte per cycle from
// the front queue unless stalled, and gives one result. Depends on ghs_pkg.
module ghs_parser import ghs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    item_take_o,
  input  logic    res_ready_i,
  output logic    res_valid_o,
  output result_t res_o,
  output logic [1:0] err_o
);

  phase_e      phase_q, phase_d;
  logic [2:0]  fixed_idx_q, fixed_idx_d;
  logic [3:0]  flags_q, flags_d;
  logic [15:0] skip_q, skip_d;
  logic [1:0]  err_q, err_d;
  logic        step;
  logic        payload;

  function automatic phase_e after_name(input logic [3:0] flg);
    phase_e ph;
    if (flg[FlagComment]) ph = PH_COMMENT;
    else if (flg[FlagHcrc]) ph = PH_HCRC0;
    else ph = PH_PAYLOAD;
    return ph;
  endfunction

  function automatic phase_e after_extra(input logic [3:0] flg);
    phase_e ph;
    if (flg[FlagName]) ph = PH_NAME;
    else ph = after_name(flg);
    return ph;
  endfunction

  assign step        = item_valid_i && res_ready_i;
  assign item_take_o = step;
  assign res_valid_o = step;
  assign err_o       = err_q;

  always_comb begin
    phase_d     = phase_q;
    fixed_idx_d = fixed_idx_q;
    flags_d     = flags_q;
    skip_d      = skip_q;
    err_d       = err_q;
    payload     = 1'b0;
    case (phase_q)
      PH_MAGIC0: begin
        if (item_i.is_magic0) phase_d = PH_MAGIC1;
        else begin
          phase_d = PH_ERROR;
          err_d   = ERR_MAGIC;
        end
      end
      PH_MAGIC1: begin
        if (item_i.is_magic1) phase_d = PH_METHOD;
        else begin
          phase_d = PH_ERROR;
          err_d   = ERR_MAGIC;
        end
      end
      PH_METHOD: begin
        if (item_i.is_deflate) phase_d = PH_FLAGS;
        else begin
          phase_d = PH_ERROR;
          err_d   = ERR_METHOD;
        end
      end
      PH_FLAGS: begin
        flags_d     = item_i.data[FlagMsb:FlagLsb];
        fixed_idx_d = 3'd0;
        phase_d     = PH_FIXED;
      end
      PH_FIXED: begin
        // MTIME, XFL and OS: six bytes in all.
        if (fixed_idx_q == FIXED_LAST) begin
          fixed_idx_d = 3'd0;
          phase_d     = flags_q[FlagExtra] ? PH_XLEN0 : after_extra(flags_q);
        end else begin
          fixed_idx_d = fixed_idx_q + 3'd1;
        end
      end
      PH_XLEN0: begin
        skip_d  = {8'd0, item_i.data};
        phase_d = PH_XLEN1;
      end
      PH_XLEN1: begin
        skip_d  = {item_i.data, skip_q[7:0]};
        phase_d = ({item_i.data, skip_q[7:0]} != 16'd0) ? PH_EXTRA : after_extra(flags_q);
      end
      PH_EXTRA: begin
        skip_d = skip_q - 16'd1;
        if (skip_q == 16'd1) phase_d = after_extra(flags_q);
      end
      PH_NAME: begin
        if (item_i.is_zero) phase_d = after_name(flags_q);
      end
      PH_COMMENT: begin
        if (item_i.is_zero) phase_d = flags_q[FlagHcrc] ? PH_HCRC0 : PH_PAYLOAD;
      end
      PH_HCRC0: phase_d = PH_HCRC1;
      PH_HCRC1: phase_d = PH_PAYLOAD;
      PH_PAYLOAD: payload = 1'b1;
      default: phase_d = PH_ERROR;
    endcase

    // A stream that ends before the header is complete is truncated.
    if (item_i.last && phase_d != PH_PAYLOAD && phase_d != PH_ERROR) begin
      phase_d = PH_ERROR;
      err_d   = ERR_TRUNC;
    end
    if (phase_d == PH_ERROR && err_d == ERR_NONE) err_d = ERR_TRUNC;
  end

  always_comb begin
    res_o.data        = item_i.data;
    res_o.is_payload  = payload;
    res_o.header_done = (phase_d == PH_PAYLOAD);
    res_o.error_code  = err_d;
    res_o.last        = item_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_MAGIC0;
      fixed_idx_q <= 3'd0;
      flags_q     <= 4'd0;
      skip_q      <= 16'd0;
      err_q       <= ERR_NONE;
    end else if (step) begin
      phase_q     <= phase_d;
      fixed_idx_q <= fixed_idx_d;
      flags_q     <= flags_d;
      skip_q      <= skip_d;
      err_q       <= err_d;
    end
  end

endmodule

>>> rtl/ghs_out_queue.sv
// Two-entry result queue that decouples the parser from the consumer.
// Depends on ghs_pkg.
module ghs_out_queue import ghs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_valid_i,
  input  result_t res_i,
  output logic    res_ready_o,
  output logic    empty,
  input  logic    pop,
  output result_t res_o
);

  result_t    mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       wr_en;
  logic       rd_en;

  assign res_ready_o = (count_q != 2'd2);
  assign wr_en       = res_valid_i && res_ready_o;
  assign empty       = (count_q == 2'd0);
  assign rd_en       = pop && !empty;
  assign res_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

>>> rtl/gzip_header_stripper.sv
// Top level of the gzip member header stripper: front queue, header parser
// and result queue. Depends on ghs_pkg, ghs_front, ghs_parser, ghs_out_queue.
//
//   Channel | Handshake         | Payload
//   --------+-------------------+------------------------------------------
//   input   | push / full       | in_byte_i, in_last_i
//   result  | empty / pop       | out_byte_o, is_payload_o, header_done_o,
//           |                   | error_code_o, out_last_o
//
// One byte per cycle sustained while neither side stalls; a pushed byte is
// held in the front queue, then one parser step puts it in the result queue.
// The parser steps whenever the front queue holds a byte and the result
// queue has room, so each side stalls on its own through the two queues.
// Reset is asynchronous and active low; it empties both queues and returns
// the parser to the first magic byte with no error latched.
module gzip_header_stripper import ghs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       is_payload_o,
  output logic       header_done_o,
  output logic [1:0] error_code_o,
  output logic       out_last_o
);

  logic       item_valid;
  item_t      item;
  logic       item_take;
  logic       res_valid;
  logic       res_ready;
  result_t    res_in;
  result_t    res_out;
  logic [1:0] err_latched;

  ghs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  ghs_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .res_ready_i  (res_ready),
    .res_valid_o  (res_valid),
    .res_o        (res_in),
    .err_o        (err_latched)
  );

  ghs_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res_in),
    .res_ready_o (res_ready),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res_out)
  );

  assign out_byte_o    = res_out.data;
  assign is_payload_o  = res_out.is_payload;
  assign header_done_o = res_out.header_done;
  assign error_code_o  = res_out.error_code;
  assign out_last_o    = res_out.last;

  // Payload bytes only follow a completed header.
  a_payload_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && is_payload_o) |-> header_done_o)
    else $error("payload byte without completed header");

  // A byte with an error attached is never payload.
  a_error_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && error_code_o != ERR_NONE) |-> (!is_payload_o && !header_done_o))
    else $error("errored byte marked as payload");

  // The error latch is sticky until reset.
  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_latched != ERR_NONE) |=> (err_latched == $past(err_latched)))
    else $error("latched error changed");

  // The parser steps only when the result queue can take its output.
  a_step_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take |-> (item_valid && res_ready))
    else $error("parser stepped without input or room");

endmodule
